FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// operation and status codes and the control word broadcast along the cells
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // what every cell does in this cycle, relative to the target index
  typedef struct packed {
    logic upd;  // overwrite the target cell
    logic ins;  // write target, cells above take the lower neighbour
    logic del;  // target and above take the upper neighbour
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ilid_cmd_if.sv
// ----------------------------------------------------------------------------
// ilid_cmd_if
// command channel: operation, position and value with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface ilid_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [4:0]  position;
  logic [31:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ilid_rsp_if.sv
// ----------------------------------------------------------------------------
// ilid_rsp_if
// response channel: read data, status and live count with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface ilid_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;
  logic [4:0]  count_after;

  modport source (output valid, read_data, status, count_after, input ready);
  modport sink   (input valid, read_data, status, count_after, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/indexed_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_top
// ordered word list with append, read, update, insert and delete at an index
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells that all shift together, so an
// insert or delete moves every later entry in the same cycle. One command beat
// is taken per clock while ready; its response is registered and appears in
// the cycle after acceptance. A new command is taken while the previous
// response is taken, so the sustained rate is one command per cycle, limited
// only by the single response register. Read can reach the first 32 entries
// (the position field is five bits). No clearing is needed after reset.
`default_nettype none

module indexed_list_insert_delete_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  ilid_cmd_if.sink  cmd,
  ilid_rsp_if.source rsp
);

  import ilid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;

  logic [CNT_W-1:0]      live_count;
  logic [CNT_W-1:0]      count_next;
  logic                  rsp_valid;
  logic [31:0]           rsp_data;
  logic [1:0]            rsp_status;
  logic [4:0]            rsp_count;

  logic                  acc;
  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      target;
  logic [DATA_WIDTH-1:0] cell_value;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word;
  logic [1:0]            status_next;
  logic [31:0]           rdata_next;
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic                  full;
  logic                  in_list;

  // no beat is taken while in reset
  assign cmd.ready = !rst && (!rsp_valid || rsp.ready);
  assign acc       = cmd.valid && cmd.ready;

  assign rsp.valid       = rsp_valid;
  assign rsp.read_data   = rsp_data;
  assign rsp.status      = rsp_status;
  assign rsp.count_after = rsp_count;

  assign cell_value = DATA_WIDTH'(cmd.value);
  assign pos_w      = CMP_W'(cmd.position);
  assign cnt_w      = CMP_W'(live_count);
  assign full       = (live_count == CNT_W'(CAPACITY));
  // live_count never exceeds capacity, so this also bounds the position
  assign in_list    = pos_w < cnt_w;

  // read port reaches only the cells the position field can address
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (cmd.position == 5'(i)) rd_word = cell_data[i];
    end
  end

  always_comb begin
    status_next = ST_OK;
    rdata_next  = '0;
    count_next  = live_count;
    ctl         = '0;
    target      = CNT_W'(cmd.position);
    case (cmd.operation)
      OP_APPEND: begin
        target = live_count;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = acc;
          count_next = live_count + 1'b1;
        end
      end
      OP_READ: begin
        if (!in_list) status_next = ST_RANGE;
        else rdata_next = 32'(rd_word);
      end
      OP_UPDATE: begin
        if (!in_list) status_next = ST_RANGE;
        else ctl.upd = acc;
      end
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status_next = ST_RANGE;
        end else begin
          ctl.ins    = acc;
          count_next = live_count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!in_list) begin
          status_next = ST_RANGE;
        end else begin
          ctl.del    = acc;
          count_next = live_count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end

    ilid_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .target     (target),
      .value      (cell_value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (acc) begin
        live_count <= count_next;
        rsp_valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_data   <= rdata_next;
      rsp_status <= status_next;
      rsp_count  <= 5'(count_next);
    end
  end

  `include "assert_macros.svh"

  `ASSERT_IMP(a_count_bound, clk, rst, 1'b1, live_count <= CNT_W'(CAPACITY))
  `ASSERT_NXT(a_rsp_follows, clk, rst, acc, rsp_valid)
  `ASSERT_NXT(a_full_no_change, clk, rst, acc && status_next == ST_FULL, $stable(live_count))
  `ASSERT_NXT(a_append_grows, clk, rst, acc && cmd.operation == OP_APPEND && !full, live_count == $past(live_count) + 1'b1)

endmodule

`default_nettype wire

FILE: rtl/core/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// one list entry; writes, or takes a neighbour's word when the list shifts
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire ilid_pkg::cell_ctl_t   ctl,
  input  wire logic [CNT_W-1:0]      target,
  input  wire logic [DATA_WIDTH-1:0] value,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  output logic      [DATA_WIDTH-1:0] data
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    if ((ctl.upd || ctl.ins) && IDX == target) begin
      data <= value;
    end else if (ctl.ins && IDX > target) begin
      data <= left_data;
    end else if (ctl.del && IDX >= target) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire
